>>> rtl/core/bsdc_pkg.sv
// Shared types, codes and constants of the block state data cache.
`default_nettype none
package bsdc_pkg;
   localparam int CACHE_BYTES  = 65536;
   localparam int LOCKED_BYTES = 16384;
   localparam int BLOCK_BYTES  = 32;
   localparam int ROW_BITS     = BLOCK_BYTES * 8;
   localparam int OFF_W        = $clog2(BLOCK_BYTES);
   localparam int LOCK_W       = $clog2(LOCKED_BYTES);
   localparam int SPAD_ROWS    = LOCKED_BYTES / BLOCK_BYTES;
   localparam int SPAD_ROW_W   = $clog2(SPAD_ROWS);
   localparam int BASE_W       = 32 - LOCK_W;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int DMA_CNT_W    = 15;

   typedef enum logic [3:0] {
      ACT_READ        = 4'd0,
      ACT_WRITE       = 4'd1,
      ACT_FLUSH       = 4'd2,
      ACT_INVALIDATE  = 4'd3,
      ACT_STORE       = 4'd4,
      ACT_TOUCH       = 4'd5,
      ACT_TOUCH_STORE = 4'd6,
      ACT_ZERO        = 4'd7,
      ACT_ZERO_LOCKED = 4'd8,
      ACT_DMA_LOAD    = 4'd9,
      ACT_DMA_STORE   = 4'd10
   } action_type;

   localparam logic [0:0] CSR_FREEZE        = 1'd0;
   localparam logic [0:0] CSR_LOCKED_ENABLE = 1'd1;

   typedef struct packed {
      logic [3:0]        action;
      logic              in_cache;
      logic [31:0]       address;
      logic [31:0]       aligned;
      logic [1:0]        access_size;
      logic [63:0]       write_data;
      logic [LOCK_W-1:0] locked_offset;
      logic [9:0]        burst_count;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type head;
   } queue_out_type;
endpackage
`default_nettype wire

>>> rtl/core/block_state_data_cache_unit.sv
// Top level of the block state data cache: register port, front end and back end.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  action, address, size, data, offset, bursts
//   rsp_      out        rsp_valid/rsp_stall  read_data, handled, locked_hit, filled, written_back
//   csr_      in         APB setup/access     freeze, locked_enable
//
// After reset the back end clears the flags and backing memory, one row per cycle,
// across all CACHE_BYTES/32 rows; transactions are stalled during that pass.
// A cache or scratchpad transaction goes from the queue head through the lookup state, with
// its registered memory read, and the execute step to the registered result. A DMA transaction
// moves 32 * burst_count bytes, each by a read then a write state through the single memory ports.
// The four-entry queue takes transactions until full, even while the back end or result stalls.
`default_nettype none
module block_state_data_cache_unit #(
   parameter int CACHE_BYTES = bsdc_pkg::CACHE_BYTES
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [3:0]                   req_action,
   input  wire  [31:0]                  req_address,
   input  wire  [1:0]                   req_access_size,
   input  wire  [63:0]                  req_write_data,
   input  wire  [bsdc_pkg::LOCK_W-1:0]  req_locked_offset,
   input  wire  [9:0]                   req_burst_count,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [63:0]                  rsp_read_data,
   output logic                         rsp_handled,
   output logic                         rsp_locked_hit,
   output logic                         rsp_filled,
   output logic                         rsp_written_back,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [2:0]                   csr_paddr,
   input  wire  [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   logic freeze_ff, freeze_in, lock_en_ff, lock_en_in;
   logic wr;
   logic clearing, pop;
   bsdc_pkg::queue_out_type queue_out;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      freeze_in  = freeze_ff;
      lock_en_in = lock_en_ff;
      if (wr) begin
         case (csr_paddr[2:2])
            bsdc_pkg::CSR_FREEZE:        freeze_in  = csr_pwdata[0];
            bsdc_pkg::CSR_LOCKED_ENABLE: lock_en_in = csr_pwdata[0];
            default:                     freeze_in  = freeze_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2:2])
         bsdc_pkg::CSR_FREEZE:        csr_prdata = {31'd0, freeze_ff};
         bsdc_pkg::CSR_LOCKED_ENABLE: csr_prdata = {31'd0, lock_en_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freeze_ff  <= 1'b0;
         lock_en_ff <= 1'b0;
      end else begin
         freeze_ff  <= freeze_in;
         lock_en_ff <= lock_en_in;
      end
   end

   bsdc_front #(.CACHE_BYTES(CACHE_BYTES)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_address       (req_address),
      .req_access_size   (req_access_size),
      .req_write_data    (req_write_data),
      .req_locked_offset (req_locked_offset),
      .req_burst_count   (req_burst_count),
      .clearing          (clearing),
      .pop               (pop),
      .queue_out         (queue_out)
   );

   bsdc_back #(.CACHE_BYTES(CACHE_BYTES)) u_back (
      .clock            (clock),
      .reset            (reset),
      .freeze           (freeze_ff),
      .locked_enable    (lock_en_ff),
      .queue_out        (queue_out),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_handled      (rsp_handled),
      .rsp_locked_hit   (rsp_locked_hit),
      .rsp_filled       (rsp_filled),
      .rsp_written_back (rsp_written_back)
   );
endmodule
`default_nettype wire

>>> rtl/core/bsdc_front.sv
// Front end: accepts transactions, aligns and classifies them, and queues them.
`default_nettype none
module bsdc_front #(
   parameter int CACHE_BYTES = bsdc_pkg::CACHE_BYTES
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [3:0]                     req_action,
   input  wire  [31:0]                    req_address,
   input  wire  [1:0]                     req_access_size,
   input  wire  [63:0]                    req_write_data,
   input  wire  [bsdc_pkg::LOCK_W-1:0]    req_locked_offset,
   input  wire  [9:0]                     req_burst_count,
   input  wire                            clearing,
   input  wire                            pop,
   output bsdc_pkg::queue_out_type        queue_out
);
   localparam int D = bsdc_pkg::QUEUE_DEPTH;
   localparam int PW = bsdc_pkg::QPTR_W;

   bsdc_pkg::op_type entry_ff [D];
   bsdc_pkg::op_type new_op;
   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          push, do_pop;
   logic [31:0]   mask;

   always_comb begin
      mask = ~((32'd1 << req_access_size) - 32'd1);
      new_op.action        = req_action;
      new_op.address       = req_address;
      new_op.aligned       = req_address & mask;
      new_op.in_cache      = (req_address & mask) < 32'(CACHE_BYTES);
      new_op.access_size   = req_access_size;
      new_op.write_data    = req_write_data;
      new_op.locked_offset = req_locked_offset;
      new_op.burst_count   = req_burst_count;
   end

   assign req_stall = clearing || (count_ff == (PW+1)'(D));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wptr_ff] <= new_op;
      end
   end

   assign queue_out.valid = (count_ff != '0);
   assign queue_out.head  = entry_ff[rptr_ff];
endmodule
`default_nettype wire

>>> rtl/core/bsdc_back.sv
// Back end: flag, cache, backing and scratchpad memories and the sequencer that carries out transactions.
`default_nettype none
module bsdc_back #(
   parameter int CACHE_BYTES = bsdc_pkg::CACHE_BYTES
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      freeze,
   input  wire                      locked_enable,
   input  bsdc_pkg::queue_out_type  queue_out,
   output logic                     pop,
   output logic                     clearing,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [63:0]              rsp_read_data,
   output logic                     rsp_handled,
   output logic                     rsp_locked_hit,
   output logic                     rsp_filled,
   output logic                     rsp_written_back
);
   localparam int ROWS  = CACHE_BYTES / bsdc_pkg::BLOCK_BYTES;
   localparam int ROW_W = $clog2(ROWS);
   localparam int RB    = bsdc_pkg::ROW_BITS;
   localparam int OW    = bsdc_pkg::OFF_W;
   localparam int SW    = bsdc_pkg::SPAD_ROW_W;
   localparam int LW    = bsdc_pkg::LOCK_W;
   localparam int CW    = bsdc_pkg::DMA_CNT_W;
   localparam int NB    = bsdc_pkg::BLOCK_BYTES;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_EXEC   = 6'b001000,
      ST_DMA_RD = 6'b010000,
      ST_DMA_WR = 6'b100000
   } state_type;

   logic          valid_mem [ROWS];
   logic          dirty_mem [ROWS];
   logic [RB-1:0] cache_mem [ROWS];
   logic [RB-1:0] back_mem  [ROWS];
   logic [RB-1:0] spad_mem  [bsdc_pkg::SPAD_ROWS];

   state_type state_ff, state_in;
   bsdc_pkg::op_type op_ff;
   logic [ROW_W-1:0] clr_ff, clr_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [bsdc_pkg::BASE_W-1:0] base_ff, base_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rdata_ff, rdata_in;
   logic             handled_ff, handled_in, lhit_ff, lhit_in;
   logic             filled_ff, filled_in, wb_ff, wb_in;

   logic             valid_q, dirty_q;
   logic [RB-1:0]    cache_q, back_q, spad_q;
   logic             rd_en;
   logic [ROW_W-1:0] row, back_ra, back_wa;
   logic [SW-1:0]    spad_ra, spad_wa;
   logic             flag_we, valid_wd, dirty_wd;
   logic             cache_we, back_we, spad_we;
   logic [RB-1:0]    cache_wd, back_wd, spad_wd;
   logic [NB-1:0]    back_be, spad_be;
   logic             lock, finish, out_free;
   logic [31:0]      m;
   logic [LW-1:0]    s;
   logic [CW-1:0]    total;
   logic [RB-1:0]    data_row;
   logic [7:0]       dma_byte;

   function automatic logic [63:0] extract(input logic [RB-1:0] r, input logic [OW-1:0] off,
                                           input logic [1:0] size);
      logic [63:0] v;
      logic [3:0]  n;
      logic [OW-1:0] idx;
      logic [2:0]  pos;
      v = '0;
      n = 4'd1 << size;
      for (int i = 0; i < 8; i++) begin
         idx = off + OW'(i);
         pos = 3'(n - 4'd1 - 4'(i));
         if (4'(i) < n) begin
            v[{pos, 3'b000} +: 8] = r[{idx, 3'b000} +: 8];
         end
      end
      return v;
   endfunction

   function automatic logic [RB-1:0] merge(input logic [RB-1:0] r, input logic [OW-1:0] off,
                                           input logic [1:0] size, input logic [63:0] w);
      logic [RB-1:0] v;
      logic [3:0]  n;
      logic [OW-1:0] idx;
      logic [2:0]  pos;
      v = r;
      n = 4'd1 << size;
      for (int i = 0; i < 8; i++) begin
         idx = off + OW'(i);
         pos = 3'(n - 4'd1 - 4'(i));
         if (4'(i) < n) begin
            v[{idx, 3'b000} +: 8] = w[{pos, 3'b000} +: 8];
         end
      end
      return v;
   endfunction

   assign row      = op_ff.aligned[ROW_W+OW-1:OW];
   assign m        = op_ff.address + 32'(k_ff);
   assign s        = op_ff.locked_offset + k_ff[LW-1:0];
   assign total    = {op_ff.burst_count, 5'b00000};
   assign lock     = locked_enable && (op_ff.address[31:LW] == base_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign clearing = (state_ff == ST_CLEAR);
   assign pop      = (state_ff == ST_IDLE) && queue_out.valid;
   assign rd_en    = (state_ff == ST_LOOKUP) || (state_ff == ST_DMA_RD);
   assign back_ra  = (state_ff == ST_DMA_RD) ? m[ROW_W+OW-1:OW] : row;
   assign spad_ra  = (state_ff == ST_DMA_RD) ? s[LW-1:OW] : op_ff.aligned[LW-1:OW];
   assign finish   = (state_ff == ST_EXEC) && out_free;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            k_in = '0;
            if (queue_out.valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (op_ff.action == bsdc_pkg::ACT_DMA_LOAD ||
                op_ff.action == bsdc_pkg::ACT_DMA_STORE) begin
               state_in = ST_DMA_RD;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_DMA_RD: begin
            state_in = (k_ff == total) ? ST_EXEC : ST_DMA_WR;
         end
         ST_DMA_WR: begin
            k_in     = k_ff + 1'b1;
            state_in = ST_DMA_RD;
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      flag_we  = 1'b0;
      valid_wd = valid_q;
      dirty_wd = dirty_q;
      cache_we = 1'b0;
      cache_wd = cache_q;
      back_we  = 1'b0;
      back_wa  = row;
      back_wd  = cache_q;
      back_be  = '1;
      spad_we  = 1'b0;
      spad_wa  = op_ff.aligned[LW-1:OW];
      spad_wd  = spad_q;
      spad_be  = '1;
      base_in  = base_ff;
      rdata_in = '0;
      handled_in = 1'b0;
      lhit_in  = 1'b0;
      filled_in = 1'b0;
      wb_in    = 1'b0;
      data_row = (valid_q || freeze) ? cache_q : back_q;
      dma_byte = '0;
      if (state_ff == ST_CLEAR) begin
         flag_we  = 1'b1;
         valid_wd = 1'b0;
         dirty_wd = 1'b0;
         back_we  = 1'b1;
         back_wa  = clr_ff;
         back_wd  = '0;
      end else if (state_ff == ST_DMA_WR) begin
         if (op_ff.action == bsdc_pkg::ACT_DMA_LOAD) begin
            if (m < 32'(CACHE_BYTES)) begin
               dma_byte = back_q[{m[OW-1:0], 3'b000} +: 8];
            end
            spad_we = 1'b1;
            spad_wa = s[LW-1:OW];
            spad_wd = {NB{dma_byte}};
            spad_be = NB'(1) << s[OW-1:0];
         end else begin
            dma_byte = spad_q[{s[OW-1:0], 3'b000} +: 8];
            back_we  = (m < 32'(CACHE_BYTES));
            back_wa  = m[ROW_W+OW-1:OW];
            back_wd  = {NB{dma_byte}};
            back_be  = NB'(1) << m[OW-1:0];
         end
      end else if (finish) begin
         case (op_ff.action)
            bsdc_pkg::ACT_READ, bsdc_pkg::ACT_WRITE: begin
               if (lock) begin
                  handled_in = 1'b1;
                  lhit_in    = 1'b1;
                  if (op_ff.action == bsdc_pkg::ACT_READ) begin
                     rdata_in = extract(spad_q, op_ff.aligned[OW-1:0], op_ff.access_size);
                  end else begin
                     spad_we = 1'b1;
                     spad_wd = merge(spad_q, op_ff.aligned[OW-1:0], op_ff.access_size,
                                     op_ff.write_data);
                  end
               end else if (op_ff.in_cache) begin
                  handled_in = 1'b1;
                  filled_in  = !valid_q && !freeze;
                  flag_we    = 1'b1;
                  valid_wd   = 1'b1;
                  if (op_ff.action == bsdc_pkg::ACT_READ) begin
                     rdata_in = extract(data_row, op_ff.aligned[OW-1:0], op_ff.access_size);
                     dirty_wd = valid_q && dirty_q;
                     cache_we = !valid_q && !freeze;
                     cache_wd = data_row;
                  end else begin
                     dirty_wd = 1'b1;
                     cache_we = 1'b1;
                     cache_wd = merge(data_row, op_ff.aligned[OW-1:0], op_ff.access_size,
                                      op_ff.write_data);
                  end
               end
            end
            bsdc_pkg::ACT_FLUSH, bsdc_pkg::ACT_STORE: begin
               if (op_ff.in_cache) begin
                  handled_in = 1'b1;
                  wb_in      = dirty_q && !freeze;
                  back_we    = dirty_q && !freeze;
                  flag_we    = 1'b1;
                  dirty_wd   = 1'b0;
                  valid_wd   = (op_ff.action == bsdc_pkg::ACT_FLUSH) ? 1'b0 : valid_q;
               end
            end
            bsdc_pkg::ACT_INVALIDATE: begin
               if (op_ff.in_cache) begin
                  handled_in = 1'b1;
                  flag_we    = 1'b1;
                  valid_wd   = 1'b0;
               end
            end
            bsdc_pkg::ACT_TOUCH, bsdc_pkg::ACT_TOUCH_STORE: begin
               if (op_ff.in_cache) begin
                  handled_in = 1'b1;
                  filled_in  = !valid_q && !freeze;
                  cache_we   = !valid_q && !freeze;
                  cache_wd   = back_q;
                  flag_we    = 1'b1;
                  valid_wd   = 1'b1;
                  dirty_wd   = (op_ff.action == bsdc_pkg::ACT_TOUCH_STORE) ||
                               (valid_q && dirty_q);
               end
            end
            bsdc_pkg::ACT_ZERO: begin
               if (op_ff.in_cache) begin
                  handled_in = 1'b1;
                  cache_we   = 1'b1;
                  cache_wd   = '0;
                  flag_we    = 1'b1;
                  valid_wd   = 1'b1;
                  dirty_wd   = 1'b1;
               end
            end
            bsdc_pkg::ACT_ZERO_LOCKED: begin
               handled_in = 1'b1;
               base_in    = op_ff.address[31:LW];
            end
            bsdc_pkg::ACT_DMA_LOAD, bsdc_pkg::ACT_DMA_STORE: begin
               handled_in = 1'b1;
            end
            default: begin
               handled_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         op_ff <= queue_out.head;
      end
      if (finish) begin
         rdata_ff   <= rdata_in;
         handled_ff <= handled_in;
         lhit_ff    <= lhit_in;
         filled_ff  <= filled_in;
         wb_ff      <= wb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         valid_q <= valid_mem[row];
         dirty_q <= dirty_mem[row];
         cache_q <= cache_mem[row];
      end
      if (flag_we) begin
         valid_mem[back_wa] <= valid_wd;
         dirty_mem[back_wa] <= dirty_wd;
      end
      if (cache_we) begin
         cache_mem[row] <= cache_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         back_q <= back_mem[back_ra];
      end
      if (back_we) begin
         for (int j = 0; j < NB; j++) begin
            if (back_be[j]) begin
               back_mem[back_wa][j*8 +: 8] <= back_wd[j*8 +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         spad_q <= spad_mem[spad_ra];
      end
      if (spad_we) begin
         for (int j = 0; j < NB; j++) begin
            if (spad_be[j]) begin
               spad_mem[spad_wa][j*8 +: 8] <= spad_wd[j*8 +: 8];
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rdata_ff;
   assign rsp_handled      = handled_ff;
   assign rsp_locked_hit   = lhit_ff;
   assign rsp_filled       = filled_ff;
   assign rsp_written_back = wb_ff;
endmodule
`default_nettype wire
